// File: rtl/ile_pkg.sv
// Shared types and constants for the indexed list engine.
// Used by ile_ctrl, ile_datapath and indexed_list_engine; depends on nothing.
package ile_pkg;

    localparam int P_CAPACITY = 256;

    localparam int KIND_W = 3;
    localparam int POS_W  = 9;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 9;

    typedef enum logic [KIND_W-1:0] {
        KIND_GET    = 3'd0,
        KIND_HEAD   = 3'd1,
        KIND_TAIL   = 3'd2,
        KIND_AT     = 3'd3,
        KIND_DELETE = 3'd4
    } t_kind;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;      // latch the incoming transaction
        logic rd_pos;    // read entry at the requested position (get)
        logic rd_move;   // read entry at the sweep index, write it one place over
        logic idx_init;  // start the sweep index
        logic idx_step;  // advance the sweep index
        logic wr_val;    // write the insert value at its position
        logic load_out;  // commit length and load the result register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic ok;
        logic is_get;
        logic is_ins;
        logic need_move;
        logic last;
        logic out_free;
    } t_dp_stat;

endpackage

// File: rtl/indexed_list_engine.sv
// Indexed list engine: ordered list of CAPACITY 32-bit values in one RAM.
// One transaction in flight; input stall is high from accept until the result is loaded.
// Steps: accept, evaluate, finish; insert places its value first. A sweep and a drain follow
// evaluate when entries shift (at or past the insert place, or past the delete place).
// Result is valid the cycle after the final state, which waits only while a held result stalls.
// Synchronous active-low reset empties the list; RAM contents are not cleared.
module indexed_list_engine #(
    parameter int CAPACITY = ile_pkg::P_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [ile_pkg::KIND_W-1:0]        i_kind,
    input  logic [ile_pkg::POS_W-1:0]         i_position,
    input  logic signed [ile_pkg::VAL_W-1:0]  i_value,
    // result channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [ile_pkg::VAL_W-1:0]  o_read_value,
    output logic [ile_pkg::ST_W-1:0]          o_status,
    output logic [ile_pkg::LEN_W-1:0]         o_list_length
);
    import ile_pkg::*;

    // Command/status pair between sequencer and datapath.
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // Sequencer: accept, evaluate, sweep (shift entries), place value, emit result.
    ile_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Datapath: entry RAM, length register, range checks and output register.
    ile_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_kind        (i_kind),
        .i_position    (i_position),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_read_value  (o_read_value),
        .o_status      (o_status),
        .o_list_length (o_list_length)
    );

endmodule

// File: rtl/ile_ctrl.sv
// Sequencer for the indexed list engine.
// Depends on ile_pkg; drives the command struct of ile_datapath.
module ile_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  ile_pkg::t_dp_stat i_stat,
    output ile_pkg::t_dp_cmd  o_cmd
);
    import ile_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = (r_state != S_IDLE);
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_stat.ok && i_stat.is_get) begin
                    o_cmd.rd_pos = 1'b1;
                    n_state      = S_FINISH;
                end else if (i_stat.ok && i_stat.need_move) begin
                    o_cmd.idx_init = 1'b1;
                    n_state        = S_SHIFT;
                end else if (i_stat.ok && i_stat.is_ins) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SHIFT: begin
                o_cmd.rd_move = 1'b1;
                if (i_stat.last) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.idx_step = 1'b1;
                end
            end
            S_DRAIN: begin
                // last moved entry is written this cycle
                n_state = i_stat.is_ins ? S_PUT : S_FINISH;
            end
            S_PUT: begin
                o_cmd.wr_val = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/ile_datapath.sv
// Datapath of the indexed list engine: entry memory, length, sweep index,
// range checks and the result register. Depends on ile_pkg.
module ile_datapath #(
    parameter int CAPACITY = ile_pkg::P_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ile_pkg::t_dp_cmd                  i_cmd,
    output ile_pkg::t_dp_stat                 o_stat,
    input  logic [ile_pkg::KIND_W-1:0]        i_kind,
    input  logic [ile_pkg::POS_W-1:0]         i_position,
    input  logic signed [ile_pkg::VAL_W-1:0]  i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [ile_pkg::VAL_W-1:0]  o_read_value,
    output logic [ile_pkg::ST_W-1:0]          o_status,
    output logic [ile_pkg::LEN_W-1:0]         o_list_length
);
    import ile_pkg::*;

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

    logic [VAL_W-1:0]  mem [CAPACITY];

    logic [KIND_W-1:0] r_kind;
    logic [POS_W-1:0]  r_pos;
    logic [VAL_W-1:0]  r_val;
    logic [LW-1:0]     r_idx;
    logic [AW-1:0]     r_wa;
    logic [VAL_W-1:0]  r_rdata;
    logic [VAL_W-1:0]  r_out_rd;
    logic [ST_W-1:0]   r_out_st;
    logic [LEN_W-1:0]  r_out_len;

    logic [LW-1:0]     r_length;
    logic [LW-1:0]     n_length;
    logic              r_pend;
    logic              n_pend;
    logic              r_out_valid;
    logic              n_out_valid;

    logic [CW-1:0]     w_pos;
    logic [CW-1:0]     w_len;
    logic [CW-1:0]     w_cap;
    logic [CW-1:0]     w_idx;
    logic [CW-1:0]     w_eff;
    logic [CW-1:0]     w_idx_init;
    logic [CW-1:0]     w_idx_step;
    logic [CW-1:0]     w_wa;
    logic [CW-1:0]     w_len_next;
    logic [AW-1:0]     w_rd_addr;
    logic              w_is_get;
    logic              w_is_ins;
    logic              w_is_del;
    logic              w_bad;
    logic              w_full;
    logic              w_ok;
    t_status           w_st;

    // ---- decode and checks ----
    always_comb begin
        w_pos    = CW'(r_pos);
        w_len    = CW'(r_length);
        w_cap    = CW'(CAPACITY);
        w_idx    = CW'(r_idx);
        w_is_get = (r_kind == KIND_GET);
        w_is_del = (r_kind == KIND_DELETE);
        w_is_ins = (r_kind == KIND_HEAD) || (r_kind == KIND_TAIL) || (r_kind == KIND_AT);

        case (r_kind)
            KIND_HEAD: w_eff = '0;
            KIND_TAIL: w_eff = w_len;
            default:   w_eff = w_pos;
        endcase

        if (w_is_get || w_is_del) begin
            w_bad = (w_pos >= w_len);
        end else if (w_is_ins) begin
            w_bad = (w_eff > w_len);
        end else begin
            w_bad = 1'b0;
        end
        w_full = w_is_ins && !w_bad && (w_len == w_cap);
        w_ok   = !w_bad && !w_full && (w_is_get || w_is_ins || w_is_del);

        if (w_bad) begin
            w_st = ST_RANGE;
        end else if (w_full) begin
            w_st = ST_FULL;
        end else begin
            w_st = ST_DONE;
        end

        // insert sweeps down from the tail, delete sweeps up from pos+1
        w_idx_init = w_is_ins ? (w_len - CW'(1)) : (w_pos + CW'(1));
        w_idx_step = w_is_ins ? (w_idx - CW'(1)) : (w_idx + CW'(1));
        w_wa       = w_is_ins ? (w_idx + CW'(1)) : (w_idx - CW'(1));

        o_stat.ok       = w_ok;
        o_stat.is_get   = w_is_get;
        o_stat.is_ins   = w_is_ins;
        o_stat.need_move = w_is_ins ? (w_eff < w_len)
                         : w_is_del ? ((w_pos + CW'(1)) < w_len) : 1'b0;
        o_stat.last     = w_is_ins ? (w_idx == w_eff) : ((w_idx + CW'(1)) == w_len);
        o_stat.out_free = !r_out_valid || !i_stall;
    end

    // read address: requested position for get, sweep index otherwise
    assign w_rd_addr = i_cmd.rd_pos ? w_pos[AW-1:0] : r_idx[AW-1:0];

    // ---- length and control next state ----
    always_comb begin
        n_length = r_length;
        if (i_cmd.load_out && w_ok && w_is_ins) begin
            n_length = r_length + LW'(1);
        end else if (i_cmd.load_out && w_ok && w_is_del) begin
            n_length = r_length - LW'(1);
        end
        w_len_next = CW'(n_length);

        n_pend = i_cmd.rd_move;

        n_out_valid = r_out_valid && i_stall;
        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length    <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_length    <= n_length;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // ---- transaction, sweep and result registers ----
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_pos  <= i_position;
            r_val  <= i_value;
        end
        if (i_cmd.idx_init) begin
            r_idx <= w_idx_init[LW-1:0];
        end else if (i_cmd.idx_step) begin
            r_idx <= w_idx_step[LW-1:0];
        end
        if (i_cmd.rd_move) begin
            r_wa <= w_wa[AW-1:0];
        end
        if (i_cmd.load_out) begin
            r_out_rd  <= (w_is_get && w_ok) ? r_rdata : '1;
            r_out_st  <= w_st;
            r_out_len <= w_len_next[LEN_W-1:0];
        end
    end

    // ---- entry memory: one write, one registered read ----
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            mem[r_wa] <= r_rdata;
        end else if (i_cmd.wr_val) begin
            mem[w_eff[AW-1:0]] <= r_val;
        end
        if (i_cmd.rd_pos || i_cmd.rd_move) begin
            r_rdata <= mem[w_rd_addr];
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_value  = r_out_rd;
    assign o_status      = r_out_st;
    assign o_list_length = r_out_len;

`ifndef SYNTH
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_len <= w_cap)
        else $error("list length above capacity");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> o_stat.out_free)
        else $error("result register overwritten");

    a_port_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !i_cmd.wr_val)
        else $error("move write and value write collide");

    a_ins_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && w_ok && w_is_ins) |=> (w_len == ($past(w_len) + CW'(1))))
        else $error("insert did not grow the list");
`endif

endmodule
